// File: src/quaternion_to_euler_angles_assert.svh
// Assertion macros for the quaternion to Euler angle block.
// Used by quaternion_to_euler_angles.sv; needs clk and rst_n in scope.
`ifndef QUATERNION_TO_EULER_ANGLES_ASSERT_SVH
`define QUATERNION_TO_EULER_ANGLES_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define QEA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define QEA_ASSERT_DLY(lbl, ante, dly, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
    else $error("assertion failed");
`else
`define QEA_ASSERT_IMP(lbl, ante, cons)
`define QEA_ASSERT_DLY(lbl, ante, dly, cons)
`endif
`endif

// File: src/qea_pkg.sv
// Shared constants and types for the quaternion to Euler angle block.
// No dependencies.
`timescale 1ns / 1ps

package qea_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_ENTRIES     = 24;

  localparam logic signed [29:0] PI_Q24    = 30'sd52707179;
  localparam logic signed [19:0] ANGLE_MAX = 20'sd25736;
  localparam logic signed [19:0] PITCH_MAX = 20'sd12868;

  // atan(2^-i) in Q.24
  localparam logic [23:0] ATAN_Q24 [ATAN_ENTRIES] = '{
    24'd13176795, 24'd7778716, 24'd4110060, 24'd2086331, 24'd1047214, 24'd524117,
    24'd262123, 24'd131069, 24'd65536, 24'd32768, 24'd16384, 24'd8192,
    24'd4096, 24'd2048, 24'd1024, 24'd512, 24'd256, 24'd128,
    24'd64, 24'd32, 24'd16, 24'd8, 24'd4, 24'd2
  };

  // normalised atan2 operands, carried alongside the square root
  typedef struct packed {
    logic signed [30:0] col0;
    logic signed [30:0] col1;
    logic signed [30:0] col2;
    logic signed [30:0] row0;
    logic signed [30:0] row1;
    logic               zr;
    logic               zy;
    logic               deg;
  } side_t;

  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [29:0] z;
  } cord_t;

  typedef struct packed {
    logic zr;
    logic zp;
    logic zy;
    logic deg;
  } flag_t;

endpackage

// File: src/quaternion_to_euler_angles.sv
// Quaternion to roll, pitch and yaw: products, normalise, square root, CORDIC.
// Depends on qea_pkg and quaternion_to_euler_angles_assert.svh.
//
//  channel | handshake          | word
//  --------+--------------------+------------------------------------------------
//  input   | start / busy       | in_quat_x, in_quat_y, in_quat_z, in_quat_w
//  result  | out_valid (strobe) | out_roll_angle, out_pitch_angle, out_yaw_angle,
//          |                    | out_degenerate
//
// One word accepted every cycle; busy is never raised.
// Pipeline: 6 arithmetic stages, a 31-stage bit-serial square root, pre-rotation,
// one stage per CORDIC step (min(CORDIC_STEPS, 24) steps), output register.
// Synchronous reset clears valid bits only; the receiver cannot stall.
`timescale 1ns / 1ps
`include "quaternion_to_euler_angles_assert.svh"

module quaternion_to_euler_angles #(
  parameter int CORDIC_STEPS = qea_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] in_quat_x,
  input  logic signed [15:0] in_quat_y,
  input  logic signed [15:0] in_quat_z,
  input  logic signed [15:0] in_quat_w,
  output logic               out_valid,
  output logic signed [15:0] out_roll_angle,
  output logic signed [14:0] out_pitch_angle,
  output logic signed [15:0] out_yaw_angle,
  output logic               out_degenerate
);

  localparam int NSTEP = (CORDIC_STEPS > qea_pkg::ATAN_ENTRIES) ?
                         qea_pkg::ATAN_ENTRIES : CORDIC_STEPS;
  localparam int SQB   = 31;
  localparam int LAT   = 39 + NSTEP;

  function automatic logic [5:0] msb_pos(input logic [32:0] m);
    logic [5:0] pos;
    pos = '0;
    for (int i = 0; i < 33; i++)
      if (m[i]) pos = 6'(i);
    return pos;
  endfunction

  function automatic logic [32:0] mag34(input logic signed [33:0] v);
    logic signed [33:0] t;
    t = v[33] ? -v : v;
    return t[32:0];
  endfunction

  function automatic logic signed [30:0] norm_shift(input logic signed [33:0] v,
                                                    input logic [5:0] pos);
    logic signed [33:0] t;
    if (pos > 6'd29) t = v >>> (pos - 6'd29);
    else             t = v <<< (6'd29 - pos);
    return $signed(t[30:0]);
  endfunction

  function automatic qea_pkg::cord_t prerot(input logic signed [33:0] x,
                                            input logic signed [33:0] y);
    qea_pkg::cord_t c;
    c.x = x;
    c.y = y;
    c.z = '0;
    if (x < 0) begin
      c.z = (y >= 0) ? qea_pkg::PI_Q24 : -qea_pkg::PI_Q24;
      c.x = -x;
      c.y = -y;
    end
    return c;
  endfunction

  function automatic qea_pkg::cord_t cstep(input qea_pkg::cord_t c, input int i);
    qea_pkg::cord_t   o;
    logic signed [33:0] xs, ys;
    logic signed [29:0] a;
    xs = c.x >>> i;
    ys = c.y >>> i;
    a  = $signed({6'b0, qea_pkg::ATAN_Q24[i]});
    if (c.y >= 0) begin
      o.x = c.x + ys;
      o.y = c.y - xs;
      o.z = c.z + a;
    end else begin
      o.x = c.x - ys;
      o.y = c.y + xs;
      o.z = c.z - a;
    end
    return o;
  endfunction

  function automatic logic signed [19:0] round_clamp(input logic signed [29:0] z,
                                                     input logic signed [19:0] lim,
                                                     input logic zero);
    logic signed [30:0] t;
    logic signed [30:0] s;
    logic signed [19:0] r;
    t = 31'(z) + 31'sd1024;
    s = t >>> 11;
    r = s[19:0];
    if (r > lim)  r = lim;
    if (r < -lim) r = -lim;
    if (zero)     r = '0;
    return r;
  endfunction

  assign busy = 1'b0;

  // stage 1: products
  logic               v1_r, deg1_r;
  logic signed [31:0] xx_r, yy_r, zz_r, ww_r, yz_r, wx_r, xz_r, wy_r, xy_r, wz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= start && !busy;
    end
    xx_r   <= in_quat_x * in_quat_x;
    yy_r   <= in_quat_y * in_quat_y;
    zz_r   <= in_quat_z * in_quat_z;
    ww_r   <= in_quat_w * in_quat_w;
    yz_r   <= in_quat_y * in_quat_z;
    wx_r   <= in_quat_w * in_quat_x;
    xz_r   <= in_quat_x * in_quat_z;
    wy_r   <= in_quat_w * in_quat_y;
    xy_r   <= in_quat_x * in_quat_y;
    wz_r   <= in_quat_w * in_quat_z;
    deg1_r <= (in_quat_x == '0) && (in_quat_y == '0) && (in_quat_z == '0) &&
              (in_quat_w == '0);
  end

  // stage 2: rotation terms, common 1/n2 dropped
  logic               v2_r, deg2_r;
  logic signed [33:0] c0_r, c1_r, c2_r, r0_r, r1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    c0_r   <= (34'(yz_r) - 34'(wx_r)) <<< 1;
    c1_r   <= 34'(ww_r) - 34'(xx_r) - 34'(yy_r) + 34'(zz_r);
    c2_r   <= -((34'(xz_r) + 34'(wy_r)) <<< 1);
    r0_r   <= (34'(xy_r) - 34'(wz_r)) <<< 1;
    r1_r   <= 34'(ww_r) + 34'(xx_r) - 34'(yy_r) - 34'(zz_r);
    deg2_r <= deg1_r;
  end

  // stage 3: leading-one search per group
  logic               v3_r, deg3_r;
  logic signed [33:0] c0_3r, c1_3r, c2_3r, r0_3r, r1_3r;
  logic [5:0]         pc_r, pr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
    c0_3r  <= c0_r;
    c1_3r  <= c1_r;
    c2_3r  <= c2_r;
    r0_3r  <= r0_r;
    r1_3r  <= r1_r;
    pc_r   <= msb_pos(mag34(c0_r) | mag34(c1_r) | mag34(c2_r));
    pr_r   <= msb_pos(mag34(r0_r) | mag34(r1_r));
    deg3_r <= deg2_r;
  end

  // stage 4: normalising shift
  logic           v4_r;
  qea_pkg::side_t s4_nxt, s4_r;

  always_comb begin
    s4_nxt.col0 = norm_shift(c0_3r, pc_r);
    s4_nxt.col1 = norm_shift(c1_3r, pc_r);
    s4_nxt.col2 = norm_shift(c2_3r, pc_r);
    s4_nxt.row0 = norm_shift(r0_3r, pr_r);
    s4_nxt.row1 = norm_shift(r1_3r, pr_r);
    s4_nxt.zr   = (c0_3r == '0) && (c1_3r == '0);
    s4_nxt.zy   = (r0_3r == '0) && (r1_3r == '0);
    s4_nxt.deg  = deg3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= v3_r;
    end
    s4_r <= s4_nxt;
  end

  // stage 5: squares; stage 6: sum
  logic               v5_r, v6_r;
  qea_pkg::side_t     s5_r, s6_r;
  logic signed [61:0] sq0_r, sq1_r;
  logic [61:0]        n6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
    sq0_r <= s4_r.col0 * s4_r.col0;
    sq1_r <= s4_r.col1 * s4_r.col1;
    s5_r  <= s4_r;
    n6_r  <= 62'(sq0_r[60:0]) + 62'(sq1_r[60:0]);
    s6_r  <= s5_r;
  end

  // square root, one result bit per stage
  logic           sqv_r  [SQB];
  logic [33:0]    rem_r  [SQB];
  logic [30:0]    q_r    [SQB];
  logic [61:0]    nr_r   [SQB];
  qea_pkg::side_t sside_r[SQB];

  for (genvar k = 0; k < SQB; k++) begin : g_sqrt
    logic           vi;
    logic [33:0]    ri, r2, tr;
    logic [30:0]    qi;
    logic [61:0]    ni;
    qea_pkg::side_t si;

    if (k == 0) begin : g_first
      assign vi = v6_r;
      assign ri = '0;
      assign qi = '0;
      assign ni = n6_r;
      assign si = s6_r;
    end else begin : g_next
      assign vi = sqv_r[k-1];
      assign ri = rem_r[k-1];
      assign qi = q_r[k-1];
      assign ni = nr_r[k-1];
      assign si = sside_r[k-1];
    end

    assign r2 = {ri[31:0], ni[61:60]};
    assign tr = {1'b0, qi, 2'b01};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sqv_r[k] <= 1'b0;
      end else begin
        sqv_r[k] <= vi;
      end
      if (r2 >= tr) begin
        rem_r[k] <= r2 - tr;
        q_r[k]   <= {qi[29:0], 1'b1};
      end else begin
        rem_r[k] <= r2;
        q_r[k]   <= {qi[29:0], 1'b0};
      end
      nr_r[k]    <= {ni[59:0], 2'b00};
      sside_r[k] <= si;
    end
  end

  // CORDIC: entry 0 is the pre-rotation, then one step per entry
  logic           cv_r [NSTEP+1];
  qea_pkg::cord_t cr_r [NSTEP+1];
  qea_pkg::cord_t cp_r [NSTEP+1];
  qea_pkg::cord_t cy_r [NSTEP+1];
  qea_pkg::flag_t cf_r [NSTEP+1];
  qea_pkg::side_t sl;

  assign sl = sside_r[SQB-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cv_r[0] <= 1'b0;
    end else begin
      cv_r[0] <= sqv_r[SQB-1];
    end
    cr_r[0]     <= prerot(34'(sl.col1), 34'(sl.col0));
    cp_r[0]     <= prerot($signed({3'b000, q_r[SQB-1]}), 34'(sl.col2));
    cy_r[0]     <= prerot(34'(sl.row1), 34'(sl.row0));
    cf_r[0].zr  <= sl.zr;
    cf_r[0].zp  <= sl.zr && (sl.col2 == '0);
    cf_r[0].zy  <= sl.zy;
    cf_r[0].deg <= sl.deg;
  end

  for (genvar i = 0; i < NSTEP; i++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        cv_r[i+1] <= 1'b0;
      end else begin
        cv_r[i+1] <= cv_r[i];
      end
      cr_r[i+1] <= cstep(cr_r[i], i);
      cp_r[i+1] <= cstep(cp_r[i], i);
      cy_r[i+1] <= cstep(cy_r[i], i);
      cf_r[i+1] <= cf_r[i];
    end
  end

  // output register
  logic               out_valid_r, deg_r;
  logic signed [19:0] roll_nxt, pitch_nxt, yaw_nxt;
  logic signed [15:0] roll_r, yaw_r;
  logic signed [14:0] pitch_r;

  assign roll_nxt  = round_clamp(cr_r[NSTEP].z, qea_pkg::ANGLE_MAX, cf_r[NSTEP].zr);
  assign pitch_nxt = round_clamp(cp_r[NSTEP].z, qea_pkg::PITCH_MAX, cf_r[NSTEP].zp);
  assign yaw_nxt   = round_clamp(cy_r[NSTEP].z, qea_pkg::ANGLE_MAX, cf_r[NSTEP].zy);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cv_r[NSTEP];
    end
    roll_r  <= roll_nxt[15:0];
    pitch_r <= pitch_nxt[14:0];
    yaw_r   <= yaw_nxt[15:0];
    deg_r   <= cf_r[NSTEP].deg;
  end

  assign out_valid       = out_valid_r;
  assign out_roll_angle  = roll_r;
  assign out_pitch_angle = pitch_r;
  assign out_yaw_angle   = yaw_r;
  assign out_degenerate  = deg_r;

  `QEA_ASSERT_DLY(a_latency, start && !busy, LAT, out_valid)
  `QEA_ASSERT_IMP(a_deg_zero, out_valid && out_degenerate,
                  out_roll_angle == '0 && out_pitch_angle == '0 && out_yaw_angle == '0)
  `QEA_ASSERT_IMP(a_roll_range, out_valid,
                  out_roll_angle <= 16'sd25736 && out_roll_angle >= -16'sd25736)
  `QEA_ASSERT_IMP(a_sqrt_flow, sqv_r[SQB-1], $past(v6_r, SQB))

endmodule
